### sv/spectrum_ballistics_peak_hold_macros.svh
// assertion macros shared by the spectrum ballistics checker
`ifndef SPECTRUM_BALLISTICS_PEAK_HOLD_MACROS_SVH
`define SPECTRUM_BALLISTICS_PEAK_HOLD_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SBPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SBPH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sbph_pkg.sv
// types and constants for the spectrum ballistics peak-hold block
`default_nettype none

package sbph_pkg;

  localparam int NUM_POINTS = 512;
  localparam int ADDR_W     = $clog2(NUM_POINTS);
  localparam int IDX_W      = 9;
  localparam int LVL_W      = 16;
  localparam int COEFF_W    = 16;
  localparam int HOLD_W     = 8;
  localparam int CFG_W      = 16;
  localparam int IDX_EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  localparam logic [COEFF_W-1:0] ATTACK_RST    = 16'd43980;
  localparam logic [COEFF_W-1:0] RELEASE_RST   = 16'd3544;
  localparam logic [LVL_W-1:0]   FALL_STEP_RST = 16'd364;
  localparam logic [HOLD_W-1:0]  HOLD_RST      = 8'd60;

  localparam logic [LVL_W-1:0] MOVE_THRESH = 16'd33;
  localparam logic [LVL_W-1:0] PEAK_THRESH = 16'd131;

  typedef enum logic [1:0] {
    CFG_ATTACK    = 2'd0,
    CFG_RELEASE   = 2'd1,
    CFG_FALL_STEP = 2'd2,
    CFG_HOLD      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0]  smooth;
    logic [LVL_W-1:0]  peak;
    logic [HOLD_W-1:0] hold;
  } ent_t;

endpackage

`default_nettype wire

### sv/spectrum_ballistics_peak_hold.sv
// spectrum display ballistics with peak hold, four-stage pipeline over a point memory
// an accepted word passes stages 1, 2 and 3, then the output register, in that order
// throughput: one word per cycle while out_stall is low; a word whose point matches
//   one of the two words ahead of it holds in stage 1 until that word's write has landed
// reset: coefficient registers load defaults, then a clearing pass zeroes all NUM_POINTS
//   (512) point memory entries in turn with in_stall high; config writes still taken
`default_nettype none

module spectrum_ballistics_peak_hold (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  sbph_pkg::cfg_idx_t             cfg_index,
  input  logic [sbph_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sbph_pkg::IDX_W-1:0]     in_point_index,
  input  logic [sbph_pkg::LVL_W-1:0]     in_target_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sbph_pkg::IDX_W-1:0]     out_index,
  output logic [sbph_pkg::LVL_W-1:0]     out_smoothed_level,
  output logic [sbph_pkg::LVL_W-1:0]     out_peak_level,
  output logic                           out_changing
);
  import sbph_pkg::*;

  // configuration
  logic [COEFF_W-1:0] attack_r, release_r;
  logic [LVL_W-1:0]   fall_step_r;
  logic [HOLD_W-1:0]  hold_frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r      <= ATTACK_RST;
      release_r     <= RELEASE_RST;
      fall_step_r   <= FALL_STEP_RST;
      hold_frames_r <= HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ATTACK:    attack_r      <= cfg_data[COEFF_W-1:0];
        CFG_RELEASE:   release_r     <= cfg_data[COEFF_W-1:0];
        CFG_FALL_STEP: fall_step_r   <= cfg_data[LVL_W-1:0];
        CFG_HOLD:      hold_frames_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == ADDR_W'(NUM_POINTS - 1)) clr_busy_r <= 1'b0;
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // pipeline registers
  logic                 v1_r, v2_r, v3_r, out_valid_r;
  logic [ADDR_W-1:0]    a1_r, a2_r, a3_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r, idx3_r;
  logic                 oor1_r, oor2_r, oor3_r;
  logic [LVL_W-1:0]     tgt1_r;
  ent_t                 rdata_r, byp_d_r, ent2_r, ent3_r;
  logic                 byp_v_r;
  logic signed [16:0]   diff2_r;
  logic [COEFF_W-1:0]   coeff2_r;
  logic [32:0]          prod3_r;

  ent_t mem [NUM_POINTS];

  // handshake and hazard control
  logic ready_o, rdy2, rdy3, adv1, adv2, adv3, hazard, accept;

  assign ready_o = !out_valid_r || !out_stall;
  assign rdy3    = !v3_r || ready_o;
  assign adv3    = v3_r && ready_o;
  assign rdy2    = !v2_r || rdy3;
  assign adv2    = v2_r && rdy3;
  // same point still in flight ahead: wait until its write has landed
  assign hazard  = v1_r && !oor1_r &&
                   ((v2_r && !oor2_r && (a2_r == a1_r)) ||
                    (v3_r && !oor3_r && (a3_r == a1_r)));
  assign adv1    = v1_r && rdy2 && !hazard;
  assign in_stall = clr_busy_r || (v1_r && !adv1);
  assign accept  = in_valid && !in_stall;

  logic [IDX_EXT_W-1:0] in_ext;
  logic [ADDR_W-1:0]    in_addr;
  logic                 in_oor;

  assign in_ext  = IDX_EXT_W'(in_point_index);
  assign in_addr = in_ext[ADDR_W-1:0];
  assign in_oor  = 32'(in_point_index) >= 32'(NUM_POINTS);

  // memory write port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  ent_t              mem_wdata, wb_ent;

  assign mem_we    = clr_busy_r || (adv3 && !oor3_r);
  assign mem_waddr = clr_busy_r ? clr_cnt_r : a3_r;
  assign mem_wdata = clr_busy_r ? ent_t'('0) : wb_ent;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept && !in_oor) rdata_r <= mem[in_addr];
  end

  // stage 1: load, with snoop of writes that land after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      byp_v_r <= 1'b0;
    end else begin
      if (accept) v1_r <= 1'b1;
      else if (adv1) v1_r <= 1'b0;
      if (accept) begin
        byp_v_r <= mem_we && (mem_waddr == in_addr);
        byp_d_r <= mem_wdata;
      end else if (mem_we && (mem_waddr == a1_r)) begin
        byp_v_r <= 1'b1;
        byp_d_r <= mem_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a1_r   <= in_addr;
      idx1_r <= in_point_index;
      tgt1_r <= in_target_level;
      oor1_r <= in_oor;
    end
  end

  ent_t               e1;
  logic signed [16:0] diff1;
  logic [COEFF_W-1:0] coeff1;

  assign e1     = byp_v_r ? byp_d_r : rdata_r;
  assign diff1  = $signed({1'b0, tgt1_r}) - $signed({1'b0, e1.smooth});
  assign coeff1 = (tgt1_r > e1.smooth) ? attack_r : release_r;

  // stage 2: multiply
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv1) v2_r <= 1'b1;
    else if (adv2) v2_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      diff2_r  <= diff1;
      coeff2_r <= coeff1;
      ent2_r   <= e1;
      a2_r     <= a1_r;
      idx2_r   <= idx1_r;
      oor2_r   <= oor1_r;
    end
  end

  logic signed [33:0] prod2;
  assign prod2 = diff2_r * $signed({1'b0, coeff2_r});

  // stage 3: floor shift, new smoothed level, peak update
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv2) v3_r <= 1'b1;
    else if (adv3) v3_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      prod3_r <= prod2[32:0];
      ent3_r  <= ent2_r;
      a3_r    <= a2_r;
      idx3_r  <= idx2_r;
      oor3_r  <= oor2_r;
    end
  end

  logic signed [16:0] step3;
  logic signed [17:0] sum3;
  logic [LVL_W-1:0]   now3, fallen3, pk_fall3, new_peak3, moved3;
  logic [HOLD_W-1:0]  hdec3, new_hold3;
  logic               ge3, changing3;

  always_comb begin
    // upper bits of the product are the floor of product / 65536
    step3 = $signed(prod3_r[32:16]);
    sum3  = $signed({2'b00, ent3_r.smooth}) + $signed({step3[16], step3});
    if (sum3[17])      now3 = '0;
    else if (sum3[16]) now3 = '1;
    else               now3 = sum3[LVL_W-1:0];

    ge3      = now3 >= ent3_r.peak;
    hdec3    = (ent3_r.hold != '0) ? ent3_r.hold - 1'b1 : '0;
    fallen3  = (ent3_r.peak > fall_step_r) ? ent3_r.peak - fall_step_r : '0;
    pk_fall3 = (fallen3 > now3) ? fallen3 : now3;
    if (ge3) begin
      new_peak3 = now3;
      new_hold3 = hold_frames_r;
    end else begin
      new_peak3 = (hdec3 == '0) ? pk_fall3 : ent3_r.peak;
      new_hold3 = hdec3;
    end

    moved3    = (now3 >= ent3_r.smooth) ? now3 - ent3_r.smooth : ent3_r.smooth - now3;
    changing3 = (moved3 > MOVE_THRESH) || (new_peak3 > PEAK_THRESH);

    wb_ent.smooth = now3;
    wb_ent.peak   = new_peak3;
    wb_ent.hold   = new_hold3;
  end

  // output register
  logic [IDX_W-1:0] out_index_r;
  logic [LVL_W-1:0] out_smooth_r, out_peak_r;
  logic             out_changing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv3) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_index_r    <= idx3_r;
      out_smooth_r   <= oor3_r ? '0 : now3;
      out_peak_r     <= oor3_r ? '0 : new_peak3;
      out_changing_r <= oor3_r ? 1'b0 : changing3;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_index          = out_index_r;
  assign out_smoothed_level = out_smooth_r;
  assign out_peak_level     = out_peak_r;
  assign out_changing       = out_changing_r;

endmodule

`default_nettype wire

### sv/sbph_checker.sv
// port-level checker for the spectrum ballistics peak-hold block, with its bind
`default_nettype none
`include "spectrum_ballistics_peak_hold_macros.svh"

module sbph_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sbph_pkg::IDX_W-1:0] out_index,
  input logic [sbph_pkg::LVL_W-1:0] out_smoothed_level,
  input logic [sbph_pkg::LVL_W-1:0] out_peak_level,
  input logic                       out_changing
);
  import sbph_pkg::*;

  logic out_held;
  assign out_held = out_valid && out_stall;

  `SBPH_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_index) && $stable(out_smoothed_level) && $stable(out_peak_level) && $stable(out_changing), "stalled result word changed")

  `SBPH_ASSERT_IMP(a_peak_ge_smooth, clk, rst_n, out_valid, out_peak_level >= out_smoothed_level, "peak level below smoothed level")

  `SBPH_ASSERT_IMP(a_peak_changing, clk, rst_n, out_valid && (out_peak_level > PEAK_THRESH), out_changing, "high peak without changing flag")

  `SBPH_ASSERT_IMP(a_clear_stall, clk, rst_n, $past(!rst_n) && !in_valid || $past(!rst_n) && in_valid, in_stall, "input taken during clearing pass")

endmodule

bind spectrum_ballistics_peak_hold sbph_checker u_sbph_checker (.*);

`default_nettype wire
